### rtl/pcmd_pkg.sv
// Shared types and constants for the position PID speed command block.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps

package pcmd_pkg;

  // Fraction bits of the gain format and of the integral.
  localparam int GAIN_FRAC_BITS = 16;

  localparam int PosW  = 32;
  localparam int ProdW = 64;
  localparam int IntW  = 48;
  // Width of the sum after the fraction bits are shifted out.
  localparam int QuotW = ProdW - GAIN_FRAC_BITS;
  localparam int CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_KP     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_KI     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_KD     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TARGET = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OFFSET = 3'd4;

  localparam logic signed [PosW-1:0] POS_MAX = {1'b0, {(PosW-1){1'b1}}};
  localparam logic signed [PosW-1:0] POS_MIN = {1'b1, {(PosW-1){1'b0}}};
  localparam logic signed [IntW-1:0] INT_MAX = {1'b0, {(IntW-1){1'b1}}};
  localparam logic signed [IntW-1:0] INT_MIN = {1'b1, {(IntW-1){1'b0}}};
  localparam logic signed [ProdW-1:0] SUM_MAX = {1'b0, {(ProdW-1){1'b1}}};
  localparam logic signed [ProdW-1:0] SUM_MIN = {1'b1, {(ProdW-1){1'b0}}};
  // Added to negative sums so the shift truncates toward zero.
  localparam logic signed [ProdW-1:0] ROUND_BIAS =
    {{(ProdW-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};

  // Control that travels with an item down the pipeline.
  typedef struct packed {
    logic valid;
    logic zero;
  } stg_t;

  // Saturating 64-bit add.
  function automatic logic signed [ProdW-1:0] sat_add(
    input logic signed [ProdW-1:0] a,
    input logic signed [ProdW-1:0] b
  );
    logic signed [ProdW:0] s;
    logic signed [ProdW-1:0] r;
    s = {a[ProdW-1], a} + {b[ProdW-1], b};
    if (s[ProdW] != s[ProdW-1]) begin
      r = s[ProdW] ? SUM_MIN : SUM_MAX;
    end else begin
      r = s[ProdW-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/position_pid_speed_command.sv
// Top level of the position PID speed command block: configuration
// registers, pipeline wiring and the result register.
// Depends on pcmd_pkg, pcmd_err, pcmd_mul and pcmd_acc.
`timescale 1ns / 1ps

// Usage:
// Each transfer on the input channel (in_valid_i, in_stall_o) carries one
// measured encoder position. Each transfer on the output channel
// (out_valid_o, out_stall_i) carries one velocity command with its settled
// and last flags. An item with nonzero error yields one result; an item
// with zero error yields the normal result and then a stop result with
// velocity 0 and settled set.
// The first result passes the input, error, product, term, sum, second sum,
// quotient and result registers. The pipeline takes one item per cycle
// unless stalled; a zero-error item holds it while the stop result leaves
// the single result register. When the receiver stalls, the whole pipeline
// holds and in_stall_o rises; items flow once the result register is free.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
// the next clock edge; indexes past the register list are ignored.
// Reset clears the gains, target, offset, integral and previous error and
// empties the pipeline.
module position_pid_speed_command import pcmd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [PosW-1:0]        cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [PosW-1:0] measured_position_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [PosW-1:0] velocity_command_o,
  output logic                   settled_o,
  output logic                   last_o
);

  logic signed [PosW-1:0]  kp_q;
  logic signed [PosW-1:0]  ki_q;
  logic signed [PosW-1:0]  kd_q;
  logic signed [PosW-1:0]  target_q;
  logic signed [PosW-1:0]  offset_q;

  logic                    adv;
  logic                    out_free;
  logic signed [PosW-1:0]  err;
  logic signed [PosW-1:0]  perr;
  stg_t                    stg2;
  stg_t                    stg3;
  stg_t                    stg7;
  logic signed [ProdW-1:0] p_prod;
  logic signed [ProdW-1:0] i_prod;
  logic signed [ProdW-1:0] d_prod;
  logic signed [QuotW-1:0] quot;
  logic signed [PosW-1:0]  vel_c;

  logic                    out_valid_q;
  logic                    pend_q;
  logic signed [PosW-1:0]  vel_q;
  logic                    settled_q;
  logic                    last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      target_q <= '0;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KP:     kp_q     <= cfg_data_i;
        CFG_KI:     ki_q     <= cfg_data_i;
        CFG_KD:     kd_q     <= cfg_data_i;
        CFG_TARGET: target_q <= cfg_data_i;
        CFG_OFFSET: offset_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The pipeline moves only when the result register takes its last stage
  // and no stop result is waiting.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = out_free && !pend_q;
  assign in_stall_o = !adv;

  pcmd_err u_err (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .meas_i     (measured_position_i),
    .target_i   (target_q),
    .offset_i   (offset_q),
    .err_o      (err),
    .perr_o     (perr),
    .stg_o      (stg2)
  );

  pcmd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .stg_i  (stg2),
    .err_i  (err),
    .perr_i (perr),
    .kp_i   (kp_q),
    .ki_i   (ki_q),
    .kd_i   (kd_q),
    .p_o    (p_prod),
    .i_o    (i_prod),
    .d_o    (d_prod),
    .stg_o  (stg3)
  );

  pcmd_acc u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .stg_i  (stg3),
    .p_i    (p_prod),
    .i_i    (i_prod),
    .d_i    (d_prod),
    .quot_o (quot),
    .stg_o  (stg7)
  );

  // Saturate the speed to 32 bits and negate it, saturating again.
  always_comb begin
    if ((&quot[QuotW-1:PosW-1]) || !(|quot[QuotW-1:PosW-1])) begin
      if (quot[PosW-1:0] == POS_MIN) begin
        vel_c = POS_MAX;
      end else begin
        vel_c = -quot[PosW-1:0];
      end
    end else if (quot[QuotW-1]) begin
      vel_c = POS_MAX;
    end else begin
      vel_c = -POS_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (out_free) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else begin
        out_valid_q <= stg7.valid;
        pend_q      <= stg7.valid && stg7.zero;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_q) begin
        vel_q     <= '0;
        settled_q <= 1'b1;
        last_q    <= 1'b1;
      end else begin
        vel_q     <= vel_c;
        settled_q <= 1'b0;
        last_q    <= !stg7.zero;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign velocity_command_o = vel_q;
  assign settled_o          = settled_q;
  assign last_o             = last_q;

  // A waiting stop result always sits behind a shown first result.
  a_pend_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q && !last_q)
    else $error("stop result pending without a first result on the port");

  // The stop result carries zero velocity and ends the item.
  a_stop_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && settled_q) |-> (last_q && vel_q == '0))
    else $error("malformed stop result");

  // A first result of a zero-error item is followed by its stop result.
  a_stop_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q && !out_stall_i) |=> (out_valid_q && settled_q))
    else $error("stop result did not follow");

  // A stalled result register freezes the input side.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input accepted while output stalled");

endmodule

### rtl/pcmd_err.sv
// Input register and position error stage of the position PID block.
// Depends on pcmd_pkg; keeps the previous error state.
`timescale 1ns / 1ps

module pcmd_err import pcmd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   in_valid_i,
  input  logic signed [PosW-1:0] meas_i,
  input  logic signed [PosW-1:0] target_i,
  input  logic signed [PosW-1:0] offset_i,
  output logic signed [PosW-1:0] err_o,
  output logic signed [PosW-1:0] perr_o,
  output stg_t                   stg_o
);

  logic                   v1_q;
  logic signed [PosW-1:0] meas_q;
  logic signed [PosW+1:0] err_wide;
  logic signed [PosW-1:0] err_c;
  logic signed [PosW-1:0] err_q;
  logic signed [PosW-1:0] perr_q;
  logic signed [PosW-1:0] prev_q;
  stg_t                   stg_q;

  assign err_wide = {{2{target_i[PosW-1]}}, target_i} - {{2{meas_q[PosW-1]}}, meas_q}
                  + {{2{offset_i[PosW-1]}}, offset_i};

  // The difference fits in 32 bits when its top three bits agree.
  always_comb begin
    if ((err_wide[PosW+1:PosW-1] == 3'b000) || (err_wide[PosW+1:PosW-1] == 3'b111)) begin
      err_c = err_wide[PosW-1:0];
    end else if (err_wide[PosW+1]) begin
      err_c = POS_MIN;
    end else begin
      err_c = POS_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      stg_q  <= '0;
      prev_q <= '0;
    end else if (adv_i) begin
      v1_q        <= in_valid_i;
      stg_q.valid <= v1_q;
      stg_q.zero  <= (err_c == '0);
      if (v1_q) begin
        prev_q <= err_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      meas_q <= meas_i;
      err_q  <= err_c;
      perr_q <= prev_q;
    end
  end

  assign err_o  = err_q;
  assign perr_o = perr_q;
  assign stg_o  = stg_q;

endmodule

### rtl/pcmd_mul.sv
// Gain product stage of the position PID block: proportional, integral
// increment and derivative products. Depends on pcmd_pkg.
`timescale 1ns / 1ps

module pcmd_mul import pcmd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  stg_t                    stg_i,
  input  logic signed [PosW-1:0]  err_i,
  input  logic signed [PosW-1:0]  perr_i,
  input  logic signed [PosW-1:0]  kp_i,
  input  logic signed [PosW-1:0]  ki_i,
  input  logic signed [PosW-1:0]  kd_i,
  output logic signed [ProdW-1:0] p_o,
  output logic signed [ProdW-1:0] i_o,
  output logic signed [ProdW-1:0] d_o,
  output stg_t                    stg_o
);

  logic signed [PosW:0]    diff;
  logic signed [ProdW-1:0] p_c;
  logic signed [ProdW-1:0] i_c;
  logic signed [ProdW-1:0] d_c;
  logic signed [ProdW-1:0] p_q;
  logic signed [ProdW-1:0] i_q;
  logic signed [ProdW-1:0] d_q;
  stg_t                    stg_q;

  assign diff = {err_i[PosW-1], err_i} - {perr_i[PosW-1], perr_i};
  // All operands are signed, so they sign-extend to the product width.
  assign p_c  = err_i * kp_i;
  assign i_c  = err_i * ki_i;
  assign d_c  = diff * kd_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_q <= '0;
    end else if (adv_i) begin
      stg_q <= stg_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_q <= p_c;
      i_q <= i_c;
      d_q <= d_c;
    end
  end

  assign p_o   = p_q;
  assign i_o   = i_q;
  assign d_o   = d_q;
  assign stg_o = stg_q;

endmodule

### rtl/pcmd_acc.sv
// Integral accumulator, term sums and fraction removal of the position PID
// block. Depends on pcmd_pkg; keeps the 48-bit integral state.
`timescale 1ns / 1ps

module pcmd_acc import pcmd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    adv_i,
  input  stg_t                    stg_i,
  input  logic signed [ProdW-1:0] p_i,
  input  logic signed [ProdW-1:0] i_i,
  input  logic signed [ProdW-1:0] d_i,
  output logic signed [QuotW-1:0] quot_o,
  output stg_t                    stg_o
);

  logic signed [IntW-1:0]  integ_q;
  logic signed [ProdW:0]   integ_sum;
  logic signed [IntW-1:0]  integ_d;
  logic signed [ProdW-1:0] p4_q;
  logic signed [ProdW-1:0] d4_q;
  logic signed [ProdW-1:0] d5_q;
  logic signed [ProdW-1:0] sum5_q;
  logic signed [ProdW-1:0] sum6_q;
  logic signed [ProdW-1:0] biased;
  logic signed [ProdW-1:0] shifted;
  logic signed [QuotW-1:0] quot_q;
  stg_t                    stg4_q;
  stg_t                    stg5_q;
  stg_t                    stg6_q;
  stg_t                    stg7_q;

  assign integ_sum = {{(ProdW-IntW+1){integ_q[IntW-1]}}, integ_q} + {i_i[ProdW-1], i_i};

  // Saturate the integral to the signed 48-bit range.
  always_comb begin
    if ((&integ_sum[ProdW:IntW-1]) || !(|integ_sum[ProdW:IntW-1])) begin
      integ_d = integ_sum[IntW-1:0];
    end else if (integ_sum[ProdW]) begin
      integ_d = INT_MIN;
    end else begin
      integ_d = INT_MAX;
    end
  end

  assign biased  = sum6_q + (sum6_q[ProdW-1] ? ROUND_BIAS : '0);
  assign shifted = biased >>> GAIN_FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      stg4_q  <= '0;
      stg5_q  <= '0;
      stg6_q  <= '0;
      stg7_q  <= '0;
    end else if (adv_i) begin
      if (stg_i.valid) begin
        integ_q <= integ_d;
      end
      stg4_q <= stg_i;
      stg5_q <= stg4_q;
      stg6_q <= stg5_q;
      stg7_q <= stg6_q;
    end
  end

  // The integral register already holds this item's value when it reaches
  // the first sum stage.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p4_q   <= p_i;
      d4_q   <= d_i;
      sum5_q <= sat_add(p4_q, {{(ProdW-IntW){integ_q[IntW-1]}}, integ_q});
      d5_q   <= d4_q;
      sum6_q <= sat_add(sum5_q, d5_q);
      quot_q <= shifted[QuotW-1:0];
    end
  end

  assign quot_o = quot_q;
  assign stg_o  = stg7_q;

endmodule
